// ----- sv/ssm_pkg.sv -----
// Shared constants and coefficient tables of the third-order state-space model.
`timescale 1ns / 1ps

package ssm_pkg;

    // Model order and fixed field widths
    localparam int N_STATE   = 3;
    localparam int COEF_W    = 32;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 32;

    // Product scalings: A is Q2.30, B is scaled by 2^40 against a Q8.8 input
    localparam int A_SHIFT   = 30;
    localparam int B_SCALE   = 48;
    localparam int INIT_FRAC = 44;

    typedef logic signed [COEF_W-1:0] coef_t;

    localparam coef_t MAT_A [N_STATE][N_STATE] = '{
        '{ 32'sd1072453334,   32'sd55759413,  -32'sd24277303 },
        '{   32'sd23858543,  -32'sd21217138,  32'sd789522363 },
        '{    32'sd1058280, -32'sd224734165, -32'sd639628005 }
    };

    localparam coef_t VEC_B [N_STATE] = '{
        -32'sd2924701, 32'sd62974199, -32'sd205845289
    };

    localparam coef_t VEC_C [N_STATE] = '{
        -32'sd1393794461, 32'sd6518907, 32'sd27767383
    };

    // Initial state held with 44 fraction bits
    localparam logic signed [63:0] INIT_Q44 [N_STATE] = '{
        -64'sd805722120834, 64'sd174162641840, -64'sd244531386017
    };

endpackage

// ----- sv/ssm_front.sv -----
// Input side: takes a sample word and forms the three B*u terms for the queue.
`timescale 1ns / 1ps

module ssm_front #(
    parameter int STATE_WIDTH = 32
) (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ssm_pkg::IN_W-1:0]   s_control_input,
    input  logic                              q_full,
    output logic                              push,
    output logic [3*(STATE_WIDTH-4)-1:0]      push_data
);
    import ssm_pkg::*;

    localparam int FRAC_W = STATE_WIDTH - 4;
    localparam int PROD_W = COEF_W + IN_W;
    localparam int B_SH   = B_SCALE - FRAC_W;

    logic signed [PROD_W-1:0] bu_prod [N_STATE];

    // Accept whenever the queue has room
    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // Scale each input term down to the state's fraction bits (floor)
    always_comb begin
        for (int i = 0; i < N_STATE; i++) begin
            bu_prod[i] = VEC_B[i] * s_control_input;
            push_data[i*FRAC_W +: FRAC_W] = bu_prod[i][PROD_W-1:B_SH];
        end
    end

endmodule

// ----- sv/ssm_queue.sv -----
// Two-entry queue that decouples the input side from the state update.
`timescale 1ns / 1ps

module ssm_queue #(
    parameter int DATA_W = 84
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              q_full,
    input  logic              pop,
    output logic              q_valid,
    output logic [DATA_W-1:0] q_data
);
    import ssm_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/ssm_core.sv -----
// State update: output C*x, next state A*x + B*u with saturation, output register.
`timescale 1ns / 1ps

module ssm_core #(
    parameter int STATE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  logic [3*(STATE_WIDTH-4)-1:0]      q_data,
    output logic                              pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ssm_pkg::OUT_W-1:0]  m_prediction,
    output logic                              m_saturated
);
    import ssm_pkg::*;

    localparam int SW       = STATE_WIDTH;
    localparam int FRAC_W   = SW - 4;
    localparam int AX_W     = COEF_W + SW;
    localparam int ACC_W    = SW + 4;
    localparam int C_SH     = FRAC_W + 2;
    localparam int YT_W     = AX_W - C_SH;
    localparam int Y_ACC_W  = YT_W + 2;
    localparam int INIT_SH  = INIT_FRAC - FRAC_W;

    logic signed [SW-1:0]      state_reg  [N_STATE];
    logic signed [SW-1:0]      state_next [N_STATE];
    logic signed [AX_W-1:0]    ax_prod    [N_STATE][N_STATE];
    logic signed [AX_W-1:0]    cx_prod    [N_STATE];
    logic signed [ACC_W-1:0]   acc        [N_STATE];
    logic [N_STATE-1:0]        x_ovf;
    logic signed [Y_ACC_W-1:0] y_acc;
    logic                      y_ovf;
    logic signed [OUT_W-1:0]   y_sat;

    logic                      m_valid_reg;
    logic signed [OUT_W-1:0]   m_prediction_reg;
    logic                      m_saturated_reg;

    // Take the next queued word when the output register is free or draining
    assign pop = q_valid && (!m_valid_reg || m_ready);

    // Output from the current state, clipped to 32 bits
    always_comb begin
        y_acc = '0;
        for (int i = 0; i < N_STATE; i++) begin
            cx_prod[i] = VEC_C[i] * state_reg[i];
            y_acc = y_acc + Y_ACC_W'($signed(cx_prod[i][AX_W-1:C_SH]));
        end
        y_ovf = (y_acc[Y_ACC_W-1:OUT_W-1] != {(Y_ACC_W-OUT_W+1){y_acc[Y_ACC_W-1]}});
        if (y_ovf) begin
            y_sat = y_acc[Y_ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                     : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            y_sat = y_acc[OUT_W-1:0];
        end
    end

    // Next state, each element clipped to the state width
    always_comb begin
        for (int i = 0; i < N_STATE; i++) begin
            acc[i] = ACC_W'($signed(q_data[i*FRAC_W +: FRAC_W]));
            for (int j = 0; j < N_STATE; j++) begin
                ax_prod[i][j] = MAT_A[i][j] * state_reg[j];
                acc[i] = acc[i] + ACC_W'($signed(ax_prod[i][j][AX_W-1:A_SHIFT]));
            end
            x_ovf[i] = (acc[i][ACC_W-1:SW-1] != {(ACC_W-SW+1){acc[i][ACC_W-1]}});
            if (x_ovf[i]) begin
                state_next[i] = acc[i][ACC_W-1] ? {1'b1, {(SW-1){1'b0}}}
                                                : {1'b0, {(SW-1){1'b1}}};
            end else begin
                state_next[i] = acc[i][SW-1:0];
            end
        end
    end

    // Hold state and output valid; reset loads the initial vector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < N_STATE; i++) begin
                state_reg[i] <= SW'(INIT_Q44[i] >>> INIT_SH);
            end
        end else begin
            if (pop) begin
                m_valid_reg <= 1'b1;
                for (int i = 0; i < N_STATE; i++) begin
                    state_reg[i] <= state_next[i];
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_prediction_reg <= y_sat;
            m_saturated_reg  <= y_ovf || (|x_ovf);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_prediction = m_prediction_reg;
    assign m_saturated  = m_saturated_reg;

endmodule

// ----- sv/state_space_model_step.sv -----
// Third-order discrete state-space model: one sample word in, one prediction word out.
// The block takes one Q8.8 sample per clock while its queue has room and returns y = C.x
// (Q16.16) from the state before the update, then moves the state to x = A.x + B.u
// (Q4.(STATE_WIDTH-4)), saturating the output and each state element and flagging any
// clipping in the same result word. Sustained rate is one sample per cycle without
// output stalls; a sample is registered in the queue and then in the output register
// before its result word appears. The rate is set by the state recurrence, which the
// back end computes combinationally from the state registers (nine A products, three C
// products and the saturating sums). A two-entry queue between the input stage, which
// forms the B.u terms, and the back end lets either side stall without the other.
// Reset loads the fixed initial state; there are no configuration registers.
`timescale 1ns / 1ps

module state_space_model_step #(
    parameter int STATE_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ssm_pkg::IN_W-1:0]   s_control_input,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ssm_pkg::OUT_W-1:0]  m_prediction,
    output logic                              m_saturated
);
    import ssm_pkg::*;

    localparam int FRAC_W = STATE_WIDTH - 4;
    localparam int Q_W    = N_STATE * FRAC_W;

    logic           push;
    logic [Q_W-1:0] push_data;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    logic [Q_W-1:0] q_data;

    ssm_front #(
        .STATE_WIDTH(STATE_WIDTH)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_control_input(s_control_input),
        .q_full         (q_full),
        .push           (push),
        .push_data      (push_data)
    );

    ssm_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .q_full   (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_data   (q_data)
    );

    ssm_core #(
        .STATE_WIDTH(STATE_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_prediction(m_prediction),
        .m_saturated (m_saturated)
    );

endmodule

// ----- sv/ssm_checker.sv -----
// Port-level checks on the state-space model, bound to the top level.
`timescale 1ns / 1ps

module ssm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [ssm_pkg::OUT_W-1:0]  m_prediction,
    input logic                              m_saturated
);
    import ssm_pkg::*;

    // Hold a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result word dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_prediction) && $stable(m_saturated)))
        else $error("stalled result word changed");

    // Reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // A fresh result follows an accepted sample through the queue and the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result word without a matching sample");

endmodule

bind state_space_model_step ssm_checker u_ssm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_prediction(m_prediction),
    .m_saturated (m_saturated)
);

// ----- verif/state_space_model_step_tb.sv -----
// Self-checking testbench for the third-order state-space model step block.
`timescale 1ns / 1ps

module state_space_model_step_tb;

    import ssm_pkg::*;

    localparam int SW         = 32;
    localparam int FRAC       = SW - 4;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRIVE_LEN  = 300;
    localparam int SEG_LEN    = 125;
    localparam int N_SEGS     = 8;

    // Model coefficients: A in Q2.30, B at 2^40, C in Q14.18, start state at 2^44
    localparam logic signed [31:0] TRANSITION [3][3] = '{
        '{ 32'sd1072453334,   32'sd55759413,  -32'sd24277303 },
        '{   32'sd23858543,  -32'sd21217138,  32'sd789522363 },
        '{    32'sd1058280, -32'sd224734165, -32'sd639628005 }
    };
    localparam logic signed [31:0] INPUT_GAIN [3] = '{
        -32'sd2924701, 32'sd62974199, -32'sd205845289
    };
    localparam logic signed [31:0] OUTPUT_GAIN [3] = '{
        -32'sd1393794461, 32'sd6518907, 32'sd27767383
    };
    localparam logic signed [63:0] START_STATE_Q44 [3] = '{
        -64'sd805722120834, 64'sd174162641840, -64'sd244531386017
    };

    localparam logic signed [95:0] PRED_MAX  = (96'sd1 <<< 31) - 96'sd1;
    localparam logic signed [95:0] PRED_MIN  = -(96'sd1 <<< 31);
    localparam logic signed [95:0] STATE_MAX = (96'sd1 <<< (SW - 1)) - 96'sd1;
    localparam logic signed [95:0] STATE_MIN = -(96'sd1 <<< (SW - 1));

    localparam logic signed [IN_W-1:0] EDGE_SAMPLES [14] = '{
        16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sh5555, -16'sd21846,
        16'sd256, -16'sd256, 16'sd128, 16'sh7F00, -16'sd32767, 16'sh00FF, 16'sh0F0F
    };

    typedef struct {
        logic signed [OUT_W-1:0] prediction;
        logic                    saturated;
    } prediction_word_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [IN_W-1:0]   s_control_input;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [OUT_W-1:0]  m_prediction;
    logic                     m_saturated;

    logic signed [SW-1:0]     model_state [3];
    prediction_word_t         expected_words [$];

    int max_gap;
    int max_stall;
    int idle_cycles;
    int mismatch_count;
    int samples_sent;
    int words_checked;
    int clipped_words;

    state_space_model_step #(
        .STATE_WIDTH     (SW)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_control_input (s_control_input),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_prediction    (m_prediction),
        .m_saturated     (m_saturated)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Answer y = C.x from the current state, then advance x = A.x + B.u
    function automatic prediction_word_t advance_model(input logic signed [IN_W-1:0] u);
        logic signed [95:0] acc;
        logic signed [95:0] term;
        logic signed [SW-1:0] next_state [3];
        prediction_word_t word;
        word.saturated = 1'b0;
        acc = '0;
        for (int i = 0; i < 3; i++) begin
            term = OUTPUT_GAIN[i] * model_state[i];
            term = term >>> (FRAC + 2);
            acc  = acc + term;
        end
        if (acc > PRED_MAX) begin
            acc = PRED_MAX;
            word.saturated = 1'b1;
        end else if (acc < PRED_MIN) begin
            acc = PRED_MIN;
            word.saturated = 1'b1;
        end
        word.prediction = acc[OUT_W-1:0];
        for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int j = 0; j < 3; j++) begin
                term = TRANSITION[i][j] * model_state[j];
                term = term >>> 30;
                acc  = acc + term;
            end
            term = INPUT_GAIN[i] * u;
            term = term >>> (48 - FRAC);
            acc  = acc + term;
            if (acc > STATE_MAX) begin
                acc = STATE_MAX;
                word.saturated = 1'b1;
            end else if (acc < STATE_MIN) begin
                acc = STATE_MIN;
                word.saturated = 1'b1;
            end
            next_state[i] = acc[SW-1:0];
        end
        for (int i = 0; i < 3; i++)
            model_state[i] = next_state[i];
        return word;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Present one sample word after a random gap and hold it until taken
    task automatic send_sample(input logic signed [IN_W-1:0] sample);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_control_input <= sample;
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(advance_model(sample));
        samples_sent++;
    endtask

    // Hold off the sender until every pending prediction has come back
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_words.size() != 0);
    endtask

    task automatic test_edge_samples();
        max_gap   = 3;
        max_stall = 3;
        foreach (EDGE_SAMPLES[i])
            send_sample(EDGE_SAMPLES[i]);
        // back-to-back extremes at full rate
        max_gap   = 0;
        max_stall = 0;
        for (int i = 0; i < 4; i++)
            send_sample(i[0] ? -16'sd32768 : 16'sd32767);
        wait_for_drain();
    endtask

    // Hold the input at each extreme for a stretch to drive the state hard
    task automatic test_clipping_drive();
        max_gap   = 0;
        max_stall = 0;
        for (int i = 0; i < DRIVE_LEN; i++)
            send_sample(16'sd32767);
        for (int i = 0; i < DRIVE_LEN; i++)
            send_sample(-16'sd32768);
        wait_for_drain();
    endtask

    task automatic test_random_stream();
        logic signed [IN_W-1:0] sample;
        int kind;
        for (int seg = 0; seg < N_SEGS; seg++) begin
            // cycle through both idling, neither, sender only, receiver only
            case (seg % 4)
                0: begin max_gap = 10; max_stall = 10; end
                1: begin max_gap = 0;  max_stall = 0;  end
                2: begin max_gap = 10; max_stall = 0;  end
                default: begin max_gap = 0; max_stall = 10; end
            endcase
            for (int i = 0; i < SEG_LEN; i++) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    case ($urandom_range(0, 3))
                        0: sample = 16'sd32767;
                        1: sample = -16'sd32768;
                        2: sample = 16'sd0;
                        default: sample = -16'sd1;
                    endcase
                end else if (kind == 1) begin
                    sample = $signed(16'($urandom_range(0, 511))) - 16'sd256;
                end else begin
                    sample = 16'($urandom());
                end
                send_sample(sample);
            end
            if (seg == N_SEGS / 2 - 1)
                wait_for_drain();
        end
    endtask

    // Receiver: stall a random number of cycles before each result word
    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = $urandom_range(0, max_stall);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        prediction_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word: prediction %0d saturated %0b",
                                          m_prediction, m_saturated));
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (m_saturated === 1'b1)
                    clipped_words++;
                if (m_prediction !== want.prediction)
                    report_mismatch($sformatf("word %0d prediction: expected %0d, got %0d",
                                              words_checked, want.prediction, m_prediction));
                if (m_saturated !== want.saturated)
                    report_mismatch($sformatf("word %0d saturated: expected %0b, got %0b",
                                              words_checked, want.saturated, m_saturated));
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog expired with %0d words pending", expected_words.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_control_input <= '0;
        max_gap        = 0;
        max_stall      = 0;
        mismatch_count = 0;
        samples_sent   = 0;
        words_checked  = 0;
        clipped_words  = 0;
        for (int i = 0; i < 3; i++)
            model_state[i] = SW'(START_STATE_Q44[i] >>> (44 - FRAC));
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_samples();
        test_clipping_drive();
        test_random_stream();

        wait_for_drain();
        repeat (10) @(posedge aclk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", expected_words.size()));

        $display("Sent %0d samples (edge values, held extreme drives, random stream)",
                 samples_sent);
        $display("Checked %0d result words, %0d with clipping flagged, %0d mismatches",
                 words_checked, clipped_words, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
